>>> rtl/dsl_pkg.sv
// ----------------------------------------------------------------------------
// dsl_pkg
// shared types and codes of the descending sorted list
// ----------------------------------------------------------------------------
package dsl_pkg;

   localparam int POS_BITS   = 5;
   localparam int FIELD_BITS = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_READ   = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type               command;
      logic [FIELD_BITS-1:0] value;
      logic [POS_BITS-1:0]   position;
   } req_type;

   typedef struct packed {
      logic                  ok;
      logic [FIELD_BITS-1:0] read_value;
      logic [POS_BITS-1:0]   where_placed;
      logic [POS_BITS-1:0]   list_length;
   } rsp_type;

   typedef struct packed {
      logic ins_en;
      logic rem_en;
   } node_ctrl_type;

endpackage

>>> rtl/dsl_cell.sv
// ----------------------------------------------------------------------------
// dsl_cell
// one slot of the list: compares, keeps, takes the new value or shifts
// ----------------------------------------------------------------------------
module dsl_cell #(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 32,
   parameter int IDX        = 0
) (
   input  logic                         clock,
   input  dsl_pkg::node_ctrl_type       ctrl,
   input  logic [dsl_pkg::POS_BITS-1:0] position,
   input  logic [$clog2(DEPTH+1)-1:0]   count,
   input  logic [VALUE_BITS-1:0]        ins_value,
   input  logic [VALUE_BITS-1:0]        left_entry,
   input  logic                         left_gt,
   input  logic [VALUE_BITS-1:0]        right_entry,
   output logic [VALUE_BITS-1:0]        entry,
   output logic                         gt,
   output logic                         take_val
);
   import dsl_pkg::*;

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_BITS) ? CW + 1 : POS_BITS + 1;

   logic [VALUE_BITS-1:0] entry_ff;
   logic [VALUE_BITS-1:0] entry_in;
   logic                  occupied;
   logic                  at_or_after;

   assign occupied    = CMPW'(IDX) < CMPW'(count);
   assign at_or_after = (CMPW'(IDX) + CMPW'(1)) >= CMPW'(position);
   assign gt          = occupied && (entry_ff > ins_value);
   assign take_val    = !gt && left_gt;
   assign entry       = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en) begin
         if (gt) begin
            entry_in = entry_ff;
         end else if (left_gt) begin
            entry_in = ins_value;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctrl.rem_en && at_or_after) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> rtl/descending_sorted_list.sv
// result: each accepted transaction's result is registered in the output register
// throughput: one transaction per cycle while a held result does not stall the request side
// the figure is set by the row of slot cells, which all shift or load at the same edge
// reset: clears the entry count and the result valid flag; slot contents are left as they are
// ----------------------------------------------------------------------------
// descending_sorted_list
// list of up to DEPTH values kept in descending order in a row of slot cells
// ----------------------------------------------------------------------------
module descending_sorted_list #(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dsl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dsl_pkg::rsp_type rsp_data
);
   import dsl_pkg::*;

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int IW   = $clog2(DEPTH);
   localparam int CMPW = (CW > POS_BITS) ? CW + 1 : POS_BITS + 1;

   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic                  accept;
   logic [VALUE_BITS-1:0] ins_value;
   logic [VALUE_BITS-1:0] entry   [DEPTH];
   logic [DEPTH-1:0]      gt;
   logic [DEPTH-1:0]      take_val;
   node_ctrl_type         ctrl;
   logic                  full;
   logic                  pos_ok;
   logic [IW-1:0]         slot;
   logic [IW:0]           slot_p1;
   logic [VALUE_BITS-1:0] rd_value;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign ins_value = VALUE_BITS'(req_data.value);
   assign full      = CMPW'(count_ff) >= CMPW'(DEPTH);
   assign pos_ok    = (req_data.position != '0) &&
                      (CMPW'(req_data.position) <= CMPW'(count_ff));

   always_comb begin
      ctrl.ins_en = accept && (req_data.command == CMD_INSERT) && !full;
      ctrl.rem_en = accept && (req_data.command == CMD_REMOVE) && pos_ok;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_node
      logic [VALUE_BITS-1:0] left_entry;
      logic                  left_gt;
      logic [VALUE_BITS-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_gt    = 1'b1;
      end else begin : g_mid
         assign left_entry = entry[i-1];
         assign left_gt    = gt[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = entry[i+1];
      end

      dsl_cell #(
         .DEPTH      (DEPTH),
         .VALUE_BITS (VALUE_BITS),
         .IDX        (i)
      ) u_node (
         .clock       (clock),
         .ctrl        (ctrl),
         .position    (req_data.position),
         .count       (count_ff),
         .ins_value   (ins_value),
         .left_entry  (left_entry),
         .left_gt     (left_gt),
         .right_entry (right_entry),
         .entry       (entry[i]),
         .gt          (gt[i]),
         .take_val    (take_val[i])
      );
   end

   // insert slot and read selection
   always_comb begin
      slot     = '0;
      rd_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (take_val[i]) begin
            slot = slot | IW'(i);
         end
         if (CMPW'(req_data.position) == CMPW'(i + 1)) begin
            rd_value = rd_value | entry[i];
         end
      end
   end

   assign slot_p1 = {1'b0, slot} + (IW+1)'(1);

   always_comb begin
      count_in = count_ff;
      rsp_in   = '0;
      case (req_data.command)
         CMD_INSERT: begin
            if (!full) begin
               count_in           = count_ff + CW'(1);
               rsp_in.ok          = 1'b1;
               rsp_in.where_placed = POS_BITS'(slot_p1);
            end
         end
         CMD_REMOVE: begin
            if (pos_ok) begin
               count_in            = count_ff - CW'(1);
               rsp_in.ok           = 1'b1;
               rsp_in.where_placed = req_data.position;
            end
         end
         CMD_READ: begin
            if (pos_ok) begin
               rsp_in.ok           = 1'b1;
               rsp_in.read_value   = FIELD_BITS'(rd_value);
               rsp_in.where_placed = req_data.position;
            end
         end
         CMD_CLEAR: begin
            count_in  = '0;
            rsp_in.ok = 1'b1;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      rsp_in.list_length = POS_BITS'(count_in);
      if (!accept) begin
         count_in = count_ff;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/dsl_checker.sv
// ----------------------------------------------------------------------------
// dsl_checker
// port-level checks of the descending sorted list
// ----------------------------------------------------------------------------
module dsl_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input dsl_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dsl_pkg::rsp_type rsp_data
);
   import dsl_pkg::*;

   // a held result keeps its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // every accepted transaction shows its result on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("no result after accepted transaction");

   // a rejected command reports no position and no data
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.where_placed == '0 && rsp_data.read_value == '0)
      else $error("rejected command carries position or data");

   // clear always succeeds and empties the list
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.command == CMD_CLEAR
      |=> rsp_data.ok && rsp_data.list_length == '0 && rsp_data.where_placed == '0)
      else $error("clear did not empty the list");

endmodule

bind descending_sorted_list dsl_checker u_dsl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> test/descending_sorted_list_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// descending_sorted_list_tb
// self-checking bench for the descending sorted list: a scoreboard keeps its
// own copy of the list, predicts the result of every accepted transaction and
// compares each returned result field by field, under varied idling and back
// pressure on both channels
// ----------------------------------------------------------------------------
module descending_sorted_list_tb;

   import dsl_pkg::*;

   localparam int LIST_DEPTH     = 16;
   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 170;

   class sorted_list_scoreboard;
      logic [FIELD_BITS-1:0] slot_value [LIST_DEPTH];
      int                    stored;
      rsp_type               expected_results [$];
      int                    error_count;
      int                    cmd_count [4];
      int                    full_rejects;
      int                    range_rejects;
      int                    longest;

      task report(string what, longint got, longint want);
         $display("%0t mismatch, %s: got %0h, want %0h", $time, what, got, want);
         error_count++;
      endtask

      function int pending();
         return expected_results.size();
      endfunction

      function void note_command(req_type t);
         rsp_type r;
         int      slot;
         int      pos;
         r   = '0;
         pos = t.position;
         cmd_count[t.command]++;
         case (t.command)
            CMD_INSERT: begin
               if (stored >= LIST_DEPTH) begin
                  full_rejects++;
               end else begin
                  slot = 0;
                  while (slot < stored && slot_value[slot] > t.value) slot++;
                  for (int i = stored; i > slot; i--) slot_value[i] = slot_value[i-1];
                  slot_value[slot] = t.value;
                  stored++;
                  r.ok           = 1'b1;
                  r.where_placed = POS_BITS'(slot + 1);
               end
            end
            CMD_CLEAR: begin
               stored = 0;
               r.ok   = 1'b1;
            end
            default: begin
               if (pos < 1 || pos > stored) begin
                  range_rejects++;
               end else begin
                  r.ok           = 1'b1;
                  r.where_placed = t.position;
                  if (t.command == CMD_REMOVE) begin
                     for (int i = pos - 1; i + 1 < stored; i++) slot_value[i] = slot_value[i+1];
                     stored--;
                  end else begin
                     r.read_value = slot_value[pos-1];
                  end
               end
            end
         endcase
         if (stored > longest) longest = stored;
         r.list_length = POS_BITS'(stored);
         expected_results.push_back(r);
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            report("result with no command pending", got.list_length, 0);
         end else begin
            want = expected_results.pop_front();
            if (got.ok !== want.ok) report("ok", got.ok, want.ok);
            if (got.read_value !== want.read_value)
               report("read_value", got.read_value, want.read_value);
            if (got.where_placed !== want.where_placed)
               report("where_placed", got.where_placed, want.where_placed);
            if (got.list_length !== want.list_length)
               report("list_length", got.list_length, want.list_length);
         end
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int      req_idle_pct = 0;
   int      rsp_idle_pct = 0;
   int      hold_ticket  = 0;
   int      hold_served  = 0;
   int      hold_left    = 0;
   bit      filling      = 1'b1;

   sorted_list_scoreboard sb;

   descending_sorted_list dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side: check, then choose the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      if (hold_ticket != hold_served) begin
         hold_served = hold_ticket;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("[descending_sorted_list] ERROR");
      $finish;
   end

   task send(req_type t);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_command(t);
   endtask

   task wait_for_drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic req_type make_cmd(cmd_type c, logic [FIELD_BITS-1:0] v,
                                        logic [POS_BITS-1:0] p);
      req_type t;
      t.command  = c;
      t.value    = v;
      t.position = p;
      return t;
   endfunction

   // mostly fill-then-drain cycles so that the full list is reached often
   function automatic req_type next_command();
      req_type     t;
      int unsigned r;
      int          len;
      len = sb.stored;
      if (len == LIST_DEPTH && $urandom_range(3) == 0) filling = 1'b0;
      if (len == 0) filling = 1'b1;
      t.value    = $urandom;
      t.position = POS_BITS'($urandom);
      case ($urandom_range(3))
         0: t.value = $urandom_range(7);
         1: begin
            case ($urandom_range(3))
               0: t.value = '0;
               1: t.value = '1;
               2: t.value = 32'h8000_0000;
               default: t.value = 32'h7fff_ffff;
            endcase
         end
         default: ;
      endcase
      r = $urandom_range(99);
      if (r == 99) t.command = CMD_CLEAR;
      else if (r < (filling ? 70 : 15)) t.command = CMD_INSERT;
      else if (r < (filling ? 82 : 40)) t.command = CMD_READ;
      else t.command = CMD_REMOVE;
      r = $urandom_range(9);
      if (r == 0) t.position = '0;
      else if (r > 1 && len > 0) t.position = POS_BITS'($urandom_range(len, 1));
      return t;
   endfunction

   task run_phase(int sender_pct, int receiver_pct, int items);
      req_idle_pct <= sender_pct;
      rsp_idle_pct <= receiver_pct;
      repeat (items) send(next_command());
      wait_for_drain();
   endtask

   initial begin : main
      sb = new;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list, extremes, equal values, bad positions, clear
      send(make_cmd(CMD_READ,   32'h1234_5678, 5'd1));
      send(make_cmd(CMD_REMOVE, 32'h0,         5'd0));
      send(make_cmd(CMD_INSERT, 32'h0,         5'd31));
      send(make_cmd(CMD_INSERT, 32'hffff_ffff, 5'd0));
      send(make_cmd(CMD_INSERT, 32'h0,         5'd16));
      send(make_cmd(CMD_INSERT, 32'h8000_0000, 5'd1));
      send(make_cmd(CMD_READ,   32'hffff_ffff, 5'd0));
      send(make_cmd(CMD_READ,   32'h0,         5'd4));
      send(make_cmd(CMD_READ,   32'h0,         5'd5));
      send(make_cmd(CMD_REMOVE, 32'h0,         5'd31));
      send(make_cmd(CMD_REMOVE, 32'h0,         5'd4));
      send(make_cmd(CMD_REMOVE, 32'h0,         5'd1));
      send(make_cmd(CMD_READ,   32'h0,         5'd1));
      send(make_cmd(CMD_CLEAR,  32'hffff_ffff, 5'd31));
      send(make_cmd(CMD_CLEAR,  32'h0,         5'd0));
      send(make_cmd(CMD_INSERT, 32'h5,         5'd0));
      send(make_cmd(CMD_READ,   32'h0,         5'd16));
      wait_for_drain();

      run_phase(24, 87, PHASE_ITEMS);
      run_phase(87, 24, PHASE_ITEMS);

      // receiver holds off while transactions keep coming, then both sides run with no idling
      req_idle_pct <= 0;
      rsp_idle_pct <= 0;
      hold_ticket  <= hold_ticket + 1;
      repeat (40) send(next_command());
      wait_for_drain();
      run_phase(0, 0, PHASE_ITEMS - 40);

      repeat (4) @(posedge clock);
      if (sb.pending() != 0) sb.report("results still pending", sb.pending(), 0);
      $display("covered %0d inserts, %0d removes, %0d reads, %0d clears",
               sb.cmd_count[CMD_INSERT], sb.cmd_count[CMD_REMOVE],
               sb.cmd_count[CMD_READ], sb.cmd_count[CMD_CLEAR]);
      $display("full-list rejects %0d, bad-position rejects %0d, longest list %0d",
               sb.full_rejects, sb.range_rejects, sb.longest);
      if (sb.error_count == 0) begin
         $display("[descending_sorted_list] OK");
      end else begin
         $display("[descending_sorted_list] ERROR");
      end
      $finish;
   end

endmodule
